FILE: rtl/core/tkr_pkg.sv
// Shared types and constants for the top-k score ranker.
// Used by every module under rtl/core; depends on nothing else.
package tkr_pkg;

    localparam int SCORE_W         = 32;
    localparam int RIDX_W          = 6;
    localparam int REQ_W           = 2;
    localparam int DEF_LIST_DEPTH  = 64;
    localparam int DEF_ID_WIDTH    = 12;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_READ   = 2'd2
    } req_t;

    // Per-list control issued by the top level for one accepted item.
    typedef struct packed {
        logic clr;
        logic ins;
    } tkr_ctrl_t;

endpackage

FILE: rtl/core/tkr_cell.sv
// One rank position of a sorted list: holds a score and an entry id.
// Depends on tkr_pkg; instantiated in a row by tkr_chain.
module tkr_cell
    import tkr_pkg::*;
#(
    parameter int ID_WIDTH = DEF_ID_WIDTH,
    parameter int CNT_W    = 7,
    parameter int INDEX    = 0
)
(
    input  logic                      clk,
    input  logic                      ins_en,
    input  logic [CNT_W-1:0]          cnt,
    input  logic signed [SCORE_W-1:0] new_score,
    input  logic [ID_WIDTH-1:0]       new_id,
    input  logic [RIDX_W-1:0]         rd_idx,
    input  logic                      left_gt,
    input  logic signed [SCORE_W-1:0] left_score,
    input  logic [ID_WIDTH-1:0]       left_id,
    output logic                      gt,
    output logic signed [SCORE_W-1:0] score,
    output logic [ID_WIDTH-1:0]       id,
    output logic [SCORE_W-1:0]        rd_score,
    output logic [ID_WIDTH-1:0]       rd_id
);

    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] score_next;
    logic [ID_WIDTH-1:0]       id_reg;
    logic [ID_WIDTH-1:0]       id_next;
    logic                      occupied;
    logic                      rd_sel;

    // An empty position always loses to the new score.
    assign occupied = (CNT_W'(INDEX) < cnt);
    assign gt       = occupied ? (new_score > score_reg) : 1'b1;

    always_comb
    begin
        score_next = score_reg;
        id_next    = id_reg;
        if (ins_en && gt)
        begin
            if (left_gt)
            begin
                score_next = left_score;
                id_next    = left_id;
            end
            else
            begin
                score_next = new_score;
                id_next    = new_id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        id_reg    <= id_next;
    end

    assign score    = score_reg;
    assign id       = id_reg;
    assign rd_sel   = (int'(rd_idx) == INDEX);
    assign rd_score = {SCORE_W{rd_sel}} & score_reg;
    assign rd_id    = {ID_WIDTH{rd_sel}} & id_reg;

endmodule

FILE: rtl/core/tkr_chain.sv
// One sorted list: a row of tkr_cell positions plus the list's fill count.
// Depends on tkr_pkg and tkr_cell.
module tkr_chain
    import tkr_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    parameter int ID_WIDTH   = DEF_ID_WIDTH,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tkr_ctrl_t                 ctrl,
    input  logic signed [SCORE_W-1:0] new_score,
    input  logic [ID_WIDTH-1:0]       new_id,
    input  logic [RIDX_W-1:0]         rd_idx,
    output logic [CNT_W-1:0]          cnt,
    output logic [CNT_W-1:0]          cnt_after_ins,
    output logic                      ins_hit,
    output logic [CNT_W-1:0]          ins_pos,
    output logic [SCORE_W-1:0]        rd_score,
    output logic [ID_WIDTH-1:0]       rd_id
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                      gt_vec   [LIST_DEPTH];
    logic signed [SCORE_W-1:0] sc_vec   [LIST_DEPTH];
    logic [ID_WIDTH-1:0]       id_vec   [LIST_DEPTH];
    logic [SCORE_W-1:0]        rsc_vec  [LIST_DEPTH];
    logic [ID_WIDTH-1:0]       rid_vec  [LIST_DEPTH];
    logic                      take_vec [LIST_DEPTH];

    for (genvar k = 0; k < LIST_DEPTH; k++)
    begin : g_cell
        logic                      l_gt;
        logic signed [SCORE_W-1:0] l_sc;
        logic [ID_WIDTH-1:0]       l_id;

        if (k == 0)
        begin : g_head
            assign l_gt = 1'b0;
            assign l_sc = '0;
            assign l_id = '0;
        end
        else
        begin : g_body
            assign l_gt = gt_vec[k-1];
            assign l_sc = sc_vec[k-1];
            assign l_id = id_vec[k-1];
        end

        tkr_cell #(
            .ID_WIDTH (ID_WIDTH),
            .CNT_W    (CNT_W),
            .INDEX    (k)
        ) u_cell (
            .clk        (clk),
            .ins_en     (ctrl.ins),
            .cnt        (count_reg),
            .new_score  (new_score),
            .new_id     (new_id),
            .rd_idx     (rd_idx),
            .left_gt    (l_gt),
            .left_score (l_sc),
            .left_id    (l_id),
            .gt         (gt_vec[k]),
            .score      (sc_vec[k]),
            .id         (id_vec[k]),
            .rd_score   (rsc_vec[k]),
            .rd_id      (rid_vec[k])
        );

        // The new pair lands in the first position it beats.
        assign take_vec[k] = gt_vec[k] & ~l_gt;
    end

    // The compare flags are monotone along the row, so the pair is stored
    // exactly when the last position loses to it.
    assign ins_hit = gt_vec[LIST_DEPTH-1];

    always_comb
    begin
        ins_pos  = '0;
        rd_score = '0;
        rd_id    = '0;
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            ins_pos  = ins_pos | ({CNT_W{take_vec[k]}} & CNT_W'(k));
            rd_score = rd_score | rsc_vec[k];
            rd_id    = rd_id | rid_vec[k];
        end
        if (!ins_hit)
        begin
            ins_pos = CNT_W'(LIST_DEPTH);
        end
    end

    assign cnt_after_ins = (ins_hit && (count_reg != CNT_W'(LIST_DEPTH)))
                         ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clr)
        begin
            count_next = '0;
        end
        else if (ctrl.ins)
        begin
            count_next = cnt_after_ins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign cnt = count_reg;

endmodule

FILE: rtl/core/top_k_score_ranker_top.sv
// Top level of the top-k score ranker: two sorted lists and a result register.
// Depends on tkr_pkg and tkr_chain (which uses tkr_cell).
//
//   Channel   Direction   Handshake             Payload
//   input     in          in_valid / in_stall   req_type, list_select, score,
//                                               entry_id, read_index
//   output    out         out_valid / out_stall hit, out_score, out_entry_id,
//                                               list_count, insert_position
//
// All positions of the selected list compare the new score against their own
// in parallel and shift right by one position in the same edge, so one item
// can be accepted in every cycle while in_stall is low.
// The result is registered and shows up on the output the cycle after the
// item is accepted. Reset clears the two fill counts and the result valid;
// the score and id storage is never cleared, since no read can reach a
// position at or beyond the count. While a result waits under out_stall,
// in_stall is raised.
module top_k_score_ranker_top
    import tkr_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    parameter int ID_WIDTH   = DEF_ID_WIDTH,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [REQ_W-1:0]          req_type,
    input  logic                      list_select,
    input  logic signed [SCORE_W-1:0] score,
    input  logic [ID_WIDTH-1:0]       entry_id,
    input  logic [RIDX_W-1:0]         read_index,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic signed [SCORE_W-1:0] out_score,
    output logic [ID_WIDTH-1:0]       out_entry_id,
    output logic [CNT_W-1:0]          list_count,
    output logic [CNT_W-1:0]          insert_position
);

    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    logic accept;

    tkr_ctrl_t          ctrl_a;
    tkr_ctrl_t          ctrl_b;
    logic [CNT_W-1:0]   cnt_a;
    logic [CNT_W-1:0]   cnt_b;
    logic [CNT_W-1:0]   cai_a;
    logic [CNT_W-1:0]   cai_b;
    logic               ihit_a;
    logic               ihit_b;
    logic [CNT_W-1:0]   ipos_a;
    logic [CNT_W-1:0]   ipos_b;
    logic [SCORE_W-1:0] rsc_a;
    logic [SCORE_W-1:0] rsc_b;
    logic [ID_WIDTH-1:0] rid_a;
    logic [ID_WIDTH-1:0] rid_b;

    // Selected-list views.
    logic [CNT_W-1:0]    sel_cnt;
    logic [CNT_W-1:0]    sel_cai;
    logic                sel_ihit;
    logic [CNT_W-1:0]    sel_ipos;
    logic [SCORE_W-1:0]  sel_rsc;
    logic [ID_WIDTH-1:0] sel_rid;
    logic                rd_in_range;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                hit_reg;
    logic                hit_next;
    logic [SCORE_W-1:0]  score_reg;
    logic [SCORE_W-1:0]  score_next;
    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] id_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    pos_next;

    // The result register frees up when it is empty or being taken.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // A clear empties both lists; an insert goes only to the selected one.
    always_comb
    begin
        ctrl_a.clr = accept && (req_type == REQ_CLEAR);
        ctrl_b.clr = ctrl_a.clr;
        ctrl_a.ins = accept && (req_type == REQ_INSERT) && !list_select;
        ctrl_b.ins = accept && (req_type == REQ_INSERT) && list_select;
    end

    tkr_chain #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .CNT_W      (CNT_W)
    ) u_chain_a (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl_a),
        .new_score     (score),
        .new_id        (entry_id),
        .rd_idx        (read_index),
        .cnt           (cnt_a),
        .cnt_after_ins (cai_a),
        .ins_hit       (ihit_a),
        .ins_pos       (ipos_a),
        .rd_score      (rsc_a),
        .rd_id         (rid_a)
    );

    tkr_chain #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .CNT_W      (CNT_W)
    ) u_chain_b (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl_b),
        .new_score     (score),
        .new_id        (entry_id),
        .rd_idx        (read_index),
        .cnt           (cnt_b),
        .cnt_after_ins (cai_b),
        .ins_hit       (ihit_b),
        .ins_pos       (ipos_b),
        .rd_score      (rsc_b),
        .rd_id         (rid_b)
    );

    always_comb
    begin
        sel_cnt  = list_select ? cnt_b  : cnt_a;
        sel_cai  = list_select ? cai_b  : cai_a;
        sel_ihit = list_select ? ihit_b : ihit_a;
        sel_ipos = list_select ? ipos_b : ipos_a;
        sel_rsc  = list_select ? rsc_b  : rsc_a;
        sel_rid  = list_select ? rid_b  : rid_a;
    end

    // A read hits only below the count; deeper positions may hold stale data.
    assign rd_in_range = (CMP_W'(read_index) < CMP_W'(sel_cnt));

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        hit_next       = hit_reg;
        score_next     = score_reg;
        id_next        = id_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            hit_next       = 1'b0;
            score_next     = '0;
            id_next        = '0;
            count_next     = sel_cnt;
            pos_next       = '0;
            case (req_type)
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                REQ_INSERT:
                begin
                    hit_next   = sel_ihit;
                    count_next = sel_cai;
                    pos_next   = sel_ipos;
                end
                REQ_READ:
                begin
                    hit_next = rd_in_range;
                    if (rd_in_range)
                    begin
                        score_next = sel_rsc;
                        id_next    = sel_rid;
                    end
                end
                default:
                begin
                    // Unused request code: report the count, change nothing.
                    count_next = sel_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        score_reg <= score_next;
        id_reg    <= id_next;
        count_reg <= count_next;
        pos_reg   <= pos_next;
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign out_score       = score_reg;
    assign out_entry_id    = id_reg;
    assign list_count      = count_reg;
    assign insert_position = pos_reg;

endmodule
